// File: rtl/cpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned CfgWidth  = 5;
  localparam int unsigned SlotWidth = 4;
  localparam int unsigned EvWidth   = 16;
  localparam int unsigned CntWidth  = 32;
  localparam logic [CfgWidth-1:0] FramesReset = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_SWEEP,
    ST_OUT
  } eng_state_e;

  // handshake between the queue and the engine
  typedef struct packed {
    logic valid;
    logic last;
  } q_ctrl_t;

endpackage : cpr_pkg
`default_nettype wire

// File: rtl/cpr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_front
// Accepts page references and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module cpr_front
  import cpr_pkg::*;
#(
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic                 last_i,
  output q_ctrl_t                   q_ctrl_o,
  output logic [PAGE_BITS-1:0]      q_page_o,
  input  wire logic                 q_pop_i
);

  logic [PAGE_BITS-1:0] page_q [2];
  logic [1:0]           last_q;
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  logic                 push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      page_q[wr_ptr_q] <= page_i;
      last_q[wr_ptr_q] <= last_i;
    end
  end

  assign q_ctrl_o.valid = (count_q != 2'd0);
  assign q_ctrl_o.last  = last_q[rd_ptr_q];
  assign q_page_o       = page_q[rd_ptr_q];

endmodule : cpr_front
`default_nettype wire

// File: rtl/cpr_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_engine
// Frame table, clock hand and totals; resolves one reference at a time and
// drives the output register.
// ----------------------------------------------------------------------------
module cpr_engine
  import cpr_pkg::*;
#(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgWidth-1:0]  cfg_wdata_i,
  input  wire q_ctrl_t              q_ctrl_i,
  input  wire logic [PAGE_BITS-1:0] q_page_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      hit_o,
  output logic [SlotWidth-1:0]      slot_o,
  output logic                      evicted_valid_o,
  output logic [EvWidth-1:0]        evicted_page_o,
  output logic [CntWidth-1:0]       hit_total_o,
  output logic [CntWidth-1:0]       miss_total_o,
  output logic                      last_result_o
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW = $clog2(FRAMES + 1);

  eng_state_e state_q, state_d;

  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [FRAMES-1:0]    ref_q, ref_d;
  logic [IW-1:0]        hand_q, hand_d;
  logic [NW-1:0]        filled_q, filled_d;
  logic [CntWidth-1:0]  hit_cnt_q, hit_cnt_d;
  logic [CntWidth-1:0]  miss_cnt_q, miss_cnt_d;
  logic [CfgWidth-1:0]  fiu_q;

  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;
  logic [FRAMES-1:0]    match_q, match_d;
  logic [FRAMES-1:0]    free_q, free_d;

  logic                 res_hit_q, res_hit_d;
  logic [IW-1:0]        res_slot_q, res_slot_d;
  logic                 res_ev_q, res_ev_d;
  logic [PAGE_BITS-1:0] res_evpage_q, res_evpage_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q;
  logic [SlotWidth-1:0] out_slot_q;
  logic                 out_ev_q;
  logic [EvWidth-1:0]   out_evpage_q;
  logic [CntWidth-1:0]  out_hit_tot_q;
  logic [CntWidth-1:0]  out_miss_tot_q;
  logic                 out_last_q;

  logic [NW-1:0]        n_frames;
  logic [IW-1:0]        match_idx, free_idx, hand_next;
  logic                 out_free, out_load, page_we, clear;
  logic [IW-1:0]        page_waddr;

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    if (fiu_q == '0) begin
      n_frames = NW'(1);
    end else if (int'(fiu_q) > int'(FRAMES)) begin
      n_frames = NW'(FRAMES);
    end else begin
      n_frames = NW'(fiu_q);
    end
  end

  // lowest set bit of the match and free vectors
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = IW'(i);
      end
      if (free_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign hand_next = ((NW'(hand_q) + NW'(1)) == n_frames) ? '0 : hand_q + IW'(1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_ctrl_i.valid) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if ((|match_q) || (|free_q)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!ref_q[hand_q]) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o      = (state_q == ST_IDLE) && q_ctrl_i.valid;
    match_d      = match_q;
    free_d       = free_q;
    valid_d      = valid_q;
    ref_d        = ref_q;
    hand_d       = hand_q;
    filled_d     = filled_q;
    hit_cnt_d    = hit_cnt_q;
    miss_cnt_d   = miss_cnt_q;
    res_hit_d    = res_hit_q;
    res_slot_d   = res_slot_q;
    res_ev_d     = res_ev_q;
    res_evpage_d = res_evpage_q;
    page_we      = 1'b0;
    page_waddr   = hand_q;
    out_load     = 1'b0;
    clear        = cfg_we_i;
    case (state_q)
      ST_MATCH: begin
        for (int i = 0; i < FRAMES; i++) begin
          match_d[i] = valid_q[i] && (frame_page_q[i] == page_q) && (NW'(i) < n_frames);
          free_d[i]  = !valid_q[i] && (NW'(i) < n_frames);
        end
        if (NW'(hand_q) >= n_frames) begin
          hand_d = '0;
        end
      end
      ST_DECIDE: begin
        res_ev_d     = 1'b0;
        res_evpage_d = '0;
        if (|match_q) begin
          res_hit_d          = 1'b1;
          res_slot_d         = match_idx;
          ref_d[match_idx]   = 1'b1;
          hit_cnt_d          = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CntWidth'(1);
        end else begin
          res_hit_d  = 1'b0;
          miss_cnt_d = (miss_cnt_q == '1) ? miss_cnt_q : miss_cnt_q + CntWidth'(1);
          if (|free_q) begin
            res_slot_d        = free_idx;
            valid_d[free_idx] = 1'b1;
            ref_d[free_idx]   = 1'b1;
            filled_d          = filled_q + NW'(1);
            page_we           = 1'b1;
            page_waddr        = free_idx;
          end
        end
      end
      ST_SWEEP: begin
        if (ref_q[hand_q]) begin
          ref_d[hand_q] = 1'b0;
          hand_d        = hand_next;
        end else begin
          res_slot_d      = hand_q;
          res_ev_d        = valid_q[hand_q];
          res_evpage_d    = valid_q[hand_q] ? frame_page_q[hand_q] : '0;
          valid_d[hand_q] = 1'b1;
          ref_d[hand_q]   = 1'b1;
          hand_d          = hand_next;
          page_we         = 1'b1;
        end
      end
      ST_OUT: begin
        out_load = out_free;
        clear    = cfg_we_i || (out_free && last_q);
      end
      default: ;
    endcase
    if (clear) begin
      valid_d    = '0;
      ref_d      = '0;
      hand_d     = '0;
      filled_d   = '0;
      hit_cnt_d  = '0;
      miss_cnt_d = '0;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      ref_q       <= '0;
      hand_q      <= '0;
      filled_q    <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fiu_q       <= FramesReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ref_q       <= ref_d;
      hand_q      <= hand_d;
      filled_q    <= filled_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fiu_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      page_q <= q_page_i;
      last_q <= q_ctrl_i.last;
    end
    if (page_we) begin
      frame_page_q[page_waddr] <= page_q;
    end
    match_q      <= match_d;
    free_q       <= free_d;
    res_hit_q    <= res_hit_d;
    res_slot_q   <= res_slot_d;
    res_ev_q     <= res_ev_d;
    res_evpage_q <= res_evpage_d;
    if (out_load) begin
      out_hit_q      <= res_hit_q;
      out_slot_q     <= SlotWidth'(res_slot_q);
      out_ev_q       <= res_ev_q;
      out_evpage_q   <= EvWidth'(res_evpage_q);
      out_hit_tot_q  <= hit_cnt_q;
      out_miss_tot_q <= miss_cnt_q;
      out_last_q     <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign slot_o          = out_slot_q;
  assign evicted_valid_o = out_ev_q;
  assign evicted_page_o  = out_evpage_q;
  assign hit_total_o     = out_hit_tot_q;
  assign miss_total_o    = out_miss_tot_q;
  assign last_result_o   = out_last_q;

endmodule : cpr_engine
`default_nettype wire

// File: rtl/clock_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second chance) page replacement over a configurable set of frames.
// ----------------------------------------------------------------------------
// One reference is resolved at a time. A hit or a fill of a free frame goes
// through the states IDLE, MATCH, DECIDE and OUT on its way from the input
// queue to the output register; a replacement adds the clock sweep, one frame
// per cycle, until the hand finds a clear reference bit. A two-entry input
// queue and the output register let both sides keep moving while the engine
// works. A frames_in_use write or a reference marked last clears all frames,
// the hand and the totals.
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgWidth-1:0]  cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic                 last_reference_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      hit_o,
  output logic [SlotWidth-1:0]      slot_o,
  output logic                      evicted_valid_o,
  output logic [EvWidth-1:0]        evicted_page_o,
  output logic [CntWidth-1:0]       hit_total_o,
  output logic [CntWidth-1:0]       miss_total_o,
  output logic                      last_result_o
);

  q_ctrl_t              q_ctrl;
  logic [PAGE_BITS-1:0] q_page;
  logic                 q_pop;

  cpr_front #(
    .PAGE_BITS(PAGE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .page_i    (page_i),
    .last_i    (last_reference_i),
    .q_ctrl_o  (q_ctrl),
    .q_page_o  (q_page),
    .q_pop_i   (q_pop)
  );

  cpr_engine #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_ctrl_i       (q_ctrl),
    .q_page_i       (q_page),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .hit_total_o    (hit_total_o),
    .miss_total_o   (miss_total_o),
    .last_result_o  (last_result_o)
  );

`ifndef NO_ASSERTIONS
  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit result reports an eviction");

  a_evict_page_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without eviction");

  a_hit_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (hit_total_o != '0))
    else $error("hit result with zero hit total");

  a_miss_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (miss_total_o != '0))
    else $error("miss result with zero miss total");
`endif

endmodule : clock_page_replacement
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for clock_page_replacement: page references go in
// through a valid/ready sender with random bursts and gaps, results are taken
// by a receiver that stalls on its own pattern. A local model of the clock
// policy predicts each result, and every result transfer is compared field by
// field with the oldest prediction. Directed traces cover fills, hits, full
// sweeps, end of trace and the frame count limits, then random traces run
// over several frame counts.
// ----------------------------------------------------------------------------
module tb;
  import cpr_pkg::*;

  localparam int unsigned NumFrames  = 16;
  localparam int unsigned PageBits   = 16;
  localparam int unsigned CycleLimit = 800000;

  typedef struct packed {
    logic                 hit;
    logic [SlotWidth-1:0] slot;
    logic                 ev_valid;
    logic [EvWidth-1:0]   ev_page;
    logic [CntWidth-1:0]  hits;
    logic [CntWidth-1:0]  misses;
    logic                 last;
  } lookup_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_we_i         = 1'b0;
  logic [CfgWidth-1:0]  cfg_wdata_i      = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic [PageBits-1:0]  page_i           = '0;
  logic                 last_reference_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic                 hit_o;
  logic [SlotWidth-1:0] slot_o;
  logic                 evicted_valid_o;
  logic [EvWidth-1:0]   evicted_page_o;
  logic [CntWidth-1:0]  hit_total_o;
  logic [CntWidth-1:0]  miss_total_o;
  logic                 last_result_o;

  clock_page_replacement #(
    .FRAMES   (NumFrames),
    .PAGE_BITS(PageBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_i          (page_i),
    .last_reference_i(last_reference_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .last_result_o   (last_result_o)
  );

  // clock policy model state
  logic [PageBits-1:0] res_page [NumFrames];
  logic                res_valid[NumFrames];
  logic                res_ref  [NumFrames];
  int unsigned         hand_pos;
  int unsigned         filled_frames;
  logic [CntWidth-1:0] hit_sum;
  logic [CntWidth-1:0] miss_sum;
  logic [CfgWidth-1:0] frames_cfg = FramesReset;

  lookup_t     predicted_lookups[$];
  lookup_t     got_lookup;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_pick;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_frames();
    for (int i = 0; i < NumFrames; i++) begin
      res_page[i]  = '0;
      res_valid[i] = 1'b0;
      res_ref[i]   = 1'b0;
    end
    hand_pos      = 0;
    filled_frames = 0;
    hit_sum       = '0;
    miss_sum      = '0;
  endfunction

  function automatic int unsigned active_frames(logic [CfgWidth-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > NumFrames) return NumFrames;
    return int'(cfg);
  endfunction

  function automatic lookup_t resolve_reference(logic [PageBits-1:0] pg, logic lst);
    lookup_t     res;
    int unsigned n;
    logic        found;
    res   = '0;
    n     = active_frames(frames_cfg);
    found = 1'b0;
    if (hand_pos >= n) hand_pos = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && res_valid[i] && res_page[i] == pg) begin
        found    = 1'b1;
        res.slot = SlotWidth'(i);
      end
    end
    if (found) begin
      res.hit           = 1'b1;
      res_ref[res.slot] = 1'b1;
      if (hit_sum != '1) hit_sum++;
    end else begin
      if (miss_sum != '1) miss_sum++;
      if (filled_frames < n) begin
        for (int i = 0; i < n; i++) begin
          if (!found && !res_valid[i]) begin
            found        = 1'b1;
            res_valid[i] = 1'b1;
            res_page[i]  = pg;
            res_ref[i]   = 1'b1;
            res.slot     = SlotWidth'(i);
            filled_frames++;
          end
        end
      end
      if (!found) begin
        // second chance sweep
        while (res_ref[hand_pos]) begin
          res_ref[hand_pos] = 1'b0;
          hand_pos = (hand_pos + 1) % n;
        end
        res.slot = SlotWidth'(hand_pos);
        if (res_valid[hand_pos]) begin
          res.ev_valid = 1'b1;
          res.ev_page  = res_page[hand_pos];
        end
        res_valid[hand_pos] = 1'b1;
        res_page[hand_pos]  = pg;
        res_ref[hand_pos]   = 1'b1;
        hand_pos = (hand_pos + 1) % n;
      end
    end
    res.hits   = hit_sum;
    res.misses = miss_sum;
    res.last   = lst;
    if (lst) clear_frames();
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_lookups.size() == 0) begin
        $error("result transfer with no reference pending");
        errors++;
      end else begin
        got_lookup = predicted_lookups.pop_front();
        check_field("hit", 32'(got_lookup.hit), 32'(hit_o));
        check_field("slot", 32'(got_lookup.slot), 32'(slot_o));
        check_field("evicted_valid", 32'(got_lookup.ev_valid), 32'(evicted_valid_o));
        check_field("evicted_page", 32'(got_lookup.ev_page), 32'(evicted_page_o));
        check_field("hit_total", got_lookup.hits, hit_total_o);
        check_field("miss_total", got_lookup.misses, miss_total_o);
        check_field("last_result", 32'(got_lookup.last), 32'(last_result_o));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 9);
      if (stall_pick < 2) begin
        out_ready_i <= 1'b1;
        stall_left  <= $urandom_range(50, 200);
      end else if (stall_pick < 5) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 24);
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_ref(input logic [PageBits-1:0] pg, input logic lst);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(0, 20);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    page_i           <= pg;
    last_reference_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_lookups.push_back(resolve_reference(pg, lst));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (predicted_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [CfgWidth-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    frames_cfg = value;
    clear_frames();
  endtask

  // reset frame count: fill all frames, hit, full sweep, end of trace
  task automatic test_fill_and_sweep();
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    for (int p = 1; p <= 14; p++) send_ref(PageBits'(p), 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h0002, 1'b1);
    send_ref(16'h0000, 1'b0);
  endtask

  // single frame, zero taken as one, oversize taken as the maximum
  task automatic test_frame_limits();
    set_frames(5'd1);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h4321, 1'b0);
    send_ref(16'h1234, 1'b1);
    set_frames(5'd0);
    send_ref(16'hA5A5, 1'b0);
    send_ref(16'h5A5A, 1'b0);
    set_frames(5'd31);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
  endtask

  task automatic test_random_traces();
    logic [CfgWidth-1:0] settings[8];
    logic [PageBits-1:0] pool[$];
    logic [PageBits-1:0] pg;
    logic                lst;
    int unsigned         n;
    int unsigned         hot;
    int unsigned         pick;
    settings = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd8, 5'd16, 5'd3};
    settings[5] = CfgWidth'($urandom_range(1, 16));
    settings[6] = CfgWidth'($urandom_range(0, 31));
    foreach (settings[s]) begin
      set_frames(settings[s]);
      n = active_frames(settings[s]);
      pool.delete();
      for (int i = 0; i < 170; i++) begin
        if (pool.size() == 0) begin
          repeat ($urandom_range(1, 2 * n + 2))
            pool.push_back(PageBits'($urandom_range(0, 65535)));
        end
        hot  = (pool.size() < n) ? pool.size() : n;
        pick = $urandom_range(0, 99);
        if (pick < 50) pg = pool[$urandom_range(0, hot - 1)];
        else if (pick < 88) pg = pool[$urandom_range(0, pool.size() - 1)];
        else pg = PageBits'($urandom_range(0, 65535));
        lst = ($urandom_range(0, 29) == 0) || (i == 169);
        send_ref(pg, lst);
        if (lst) pool.delete();
      end
    end
  endtask

  initial begin
    clear_frames();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_sweep();
    test_frame_limits();
    test_random_traces();
    drain_results();
    repeat (NumFrames + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
